/* design/lpe_pkg.sv */
package lpe_pkg;

  // item field widths
  localparam int DEG_W = 6;
  localparam int DEG_N = 1 << DEG_W;
  localparam int X_W   = 32;
  localparam int VAL_W = 34;

  // fixed-point formats
  localparam int FRAC_BITS  = 30;
  localparam int RECIP_BITS = 48;
  localparam int SQRT_BITS  = 28;
  localparam int RECIP_W    = 48;
  localparam int FAC_W      = 50;

  // shared multiplier: a operand, b operand split into two halves
  localparam int MUL_A_W  = 40;
  localparam int MUL_B_W  = 50;
  localparam int MUL_BH_W = MUL_B_W / 2;
  localparam int MUL_P_W  = MUL_A_W + MUL_BH_W;
  localparam int ACC_W    = MUL_A_W + MUL_B_W;

  // datapath register widths
  localparam int P0_W  = 33;
  localparam int P1_W  = 35;
  localparam int T_W   = 34;
  localparam int D_W   = 35;
  localparam int E_W   = 34;
  localparam int NUM_W = 40;
  localparam int NP_W  = 42;
  localparam int Q_W   = 42;

  // 1/(2*sqrt(pi)) in Q48
  localparam logic [63:0] INV_2SQRTPI_Q48 = (64'd1211587905 << 16) + 64'd2670;

  // limits and constants
  localparam logic signed [X_W-1:0]  X_LIM   = X_W'(64'd1 << FRAC_BITS);
  localparam logic signed [P1_W-1:0] P_ONE   = P1_W'(64'd1 << FRAC_BITS);
  localparam logic signed [Q_W-1:0]  P_LIM   = Q_W'(64'd1 << (FRAC_BITS + 1));
  localparam logic signed [P1_W-1:0] OUT_LIM = P1_W'(64'd1 << 32);
  localparam logic [ACC_W-1:0] HALF_T = ACC_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [ACC_W-1:0] HALF_Q = ACC_W'(64'd1 << (RECIP_BITS - 1));

  // configuration register map
  localparam logic REG_NORMALIZE = 1'b0;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MS_T,
    MS_Q,
    MS_N
  } mul_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     mul_en;
    logic     mul_hi;
    mul_sel_e mul_sel;
    logic     t_en;
    logic     de_en;
    logic     num_en;
    logic     q_en;
    logic     nrm_en;
    logic     out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_deg_lt2;
    logic last_step;
  } dp_stat_t;

  // sqrt((2l+1)/(4*pi)) in Q48, worked out at elaboration
  function automatic logic [FAC_W-1:0] norm_factor(input int unsigned deg);
    logic [63:0]  v;
    logic [63:0]  r;
    logic [63:0]  b;
    logic [127:0] prod;
    v = 64'(2 * deg + 1) << (2 * SQRT_BITS);
    r = 64'd0;
    for (int i = 31; i >= 0; i--) begin
      b = 64'd1 << (2 * i);
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    if (v > r) begin
      r = r + 64'd1;
    end
    prod = 128'(r) * 128'(INV_2SQRTPI_Q48) + (128'd1 << (SQRT_BITS - 1));
    return FAC_W'(prod >> SQRT_BITS);
  endfunction

endpackage

/* design/legendre_polynomial_evaluator_top.sv */
// Legendre polynomial evaluator: each item gives a degree l (0 to 63) and an argument
// x in Q2.30, saturated to [-1, 1]; the result is P_l(x) in Q30, built with the Bonnet
// recurrence n*P_n = (2n-1)*x*P_{n-1} - (n-1)*P_{n-2}, division by n done as a multiply
// by a rounded Q48 reciprocal, every recurrence value held to +-2 and the result held
// to +-4. Setting bit 0 of the normalize register (byte address 0) scales the result
// by sqrt((2l+1)/(4*pi)), giving Y_l0 when x is cos(theta). One item is in work at a
// time; the next is taken once the previous result sits in the output register, which
// holds it while the consumer stalls. Items of degree 0 or 1 skip the recurrence; each
// step of it makes two passes through one shared 40x25-bit multiplier for each of its
// two products, with rounding and the numerator arithmetic in states of their own, and
// normalisation adds one more two-pass multiply with a rounding state of its own.
module legendre_polynomial_evaluator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lpe_pkg::DEG_W-1:0]        degree_i,
  input  logic signed [lpe_pkg::X_W-1:0]   cos_value_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [lpe_pkg::VAL_W-1:0] value_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  lpe_pkg::dp_cmd_t  cmd;
  lpe_pkg::dp_stat_t stat;
  logic              normalize_q;
  logic              cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == lpe_pkg::REG_NORMALIZE);
  assign prdata = (paddr[2] == lpe_pkg::REG_NORMALIZE) ? {31'd0, normalize_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normalize_q <= 1'b0;
    end else if (cfg_wr) begin
      normalize_q <= pwdata[0];
    end
  end

  lpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .normalize_i (normalize_q),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lpe_dp u_dp (
    .clk_i       (clk_i),
    .degree_i    (degree_i),
    .cos_value_i (cos_value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_o     (value_o)
  );

  // an accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again straight after an accepted item");

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("output register loaded while its item is stalled");

  // results stay within +-4
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (35'(value_o) <= lpe_pkg::OUT_LIM) && (35'(value_o) >= -lpe_pkg::OUT_LIM))
    else $error("result outside the saturation range");

  // the output register is loaded only while no input is being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> in_stall_o && !cmd.load)
    else $error("result loaded while idle");

endmodule

/* design/lpe_ctrl.sv */
module lpe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              normalize_i,
  input  lpe_pkg::dp_stat_t stat_i,
  output lpe_pkg::dp_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TA   = 4'd1;
  localparam logic [3:0] S_TB   = 4'd2;
  localparam logic [3:0] S_TR   = 4'd3;
  localparam logic [3:0] S_TD   = 4'd4;
  localparam logic [3:0] S_TN   = 4'd5;
  localparam logic [3:0] S_QA   = 4'd6;
  localparam logic [3:0] S_QB   = 4'd7;
  localparam logic [3:0] S_QR   = 4'd8;
  localparam logic [3:0] S_NA   = 4'd9;
  localparam logic [3:0] S_NB   = 4'd10;
  localparam logic [3:0] S_NR   = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = lpe_pkg::MS_T;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (!stat_i.in_deg_lt2) begin
            state_d = S_TA;
          end else if (normalize_i) begin
            state_d = S_NA;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_TA: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_TB;
      end
      S_TB: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = 1'b1;
        state_d      = S_TR;
      end
      S_TR: begin
        cmd_o.t_en = 1'b1;
        state_d    = S_TD;
      end
      S_TD: begin
        cmd_o.de_en = 1'b1;
        state_d     = S_TN;
      end
      S_TN: begin
        cmd_o.num_en = 1'b1;
        state_d      = S_QA;
      end
      S_QA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lpe_pkg::MS_Q;
        state_d       = S_QB;
      end
      S_QB: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_hi  = 1'b1;
        cmd_o.mul_sel = lpe_pkg::MS_Q;
        state_d       = S_QR;
      end
      S_QR: begin
        cmd_o.q_en = 1'b1;
        if (!stat_i.last_step) begin
          state_d = S_TA;
        end else if (normalize_i) begin
          state_d = S_NA;
        end else begin
          state_d = S_FIN;
        end
      end
      S_NA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lpe_pkg::MS_N;
        state_d       = S_NB;
      end
      S_NB: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_hi  = 1'b1;
        cmd_o.mul_sel = lpe_pkg::MS_N;
        state_d       = S_NR;
      end
      S_NR: begin
        cmd_o.nrm_en = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register occupancy
  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* design/lpe_dp.sv */
module lpe_dp (
  input  logic                                clk_i,
  input  logic [lpe_pkg::DEG_W-1:0]           degree_i,
  input  logic signed [lpe_pkg::X_W-1:0]      cos_value_i,
  input  lpe_pkg::dp_cmd_t                    cmd_i,
  output lpe_pkg::dp_stat_t                   stat_o,
  output logic signed [lpe_pkg::VAL_W-1:0]    value_o
);

  // constant tables: reciprocals of n and normalisation factors of l
  logic [lpe_pkg::RECIP_W-1:0] recip_tbl [lpe_pkg::DEG_N];
  logic [lpe_pkg::FAC_W-1:0]   fac_tbl   [lpe_pkg::DEG_N];

  for (genvar g = 0; g < lpe_pkg::DEG_N; g++) begin : g_tbl
    localparam logic [63:0] DIV_N = 64'((g < 2) ? 1 : g);
    localparam logic [lpe_pkg::RECIP_W-1:0] RECIP_VAL = (g < 2) ? '0 :
        lpe_pkg::RECIP_W'(((64'd1 << lpe_pkg::RECIP_BITS) + 64'(g / 2)) / DIV_N);
    localparam logic [lpe_pkg::FAC_W-1:0] FAC_VAL = lpe_pkg::norm_factor(g);
    assign recip_tbl[g] = RECIP_VAL;
    assign fac_tbl[g]   = FAC_VAL;
  end

  logic [lpe_pkg::DEG_W-1:0]          deg_q, n_q;
  logic signed [lpe_pkg::X_W-1:0]     x_q, x_clamped;
  logic signed [lpe_pkg::P0_W-1:0]    p0_q;
  logic signed [lpe_pkg::P1_W-1:0]    p1_q;
  logic signed [lpe_pkg::T_W-1:0]     t_q, t_d;
  logic signed [lpe_pkg::D_W-1:0]     d_q, d_d;
  logic signed [lpe_pkg::E_W-1:0]     e_q, e_d;
  logic signed [lpe_pkg::NUM_W-1:0]   num_q, num_d;
  logic signed [lpe_pkg::NP_W-1:0]    nd_prod;
  logic signed [lpe_pkg::VAL_W-1:0]   value_q, value_d;

  logic [lpe_pkg::MUL_A_W-1:0]  mul_a;
  logic [lpe_pkg::MUL_B_W-1:0]  mul_b;
  logic [lpe_pkg::MUL_BH_W-1:0] mul_b_part;
  logic [lpe_pkg::MUL_P_W-1:0]  mul_pp;
  logic [lpe_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic                         neg_q, neg_d;
  logic [lpe_pkg::P1_W-1:0]     p1_mag;
  logic [lpe_pkg::X_W-1:0]      x_mag;
  logic [lpe_pkg::NUM_W-1:0]    num_mag;

  logic [lpe_pkg::ACC_W-1:0]    rnd_t, rnd_q;
  logic [lpe_pkg::T_W-1:0]      t_mag;
  logic [lpe_pkg::Q_W-1:0]      q_mag;
  logic signed [lpe_pkg::Q_W-1:0] q_s, q_sat;

  // argument saturated to [-1, 1]
  always_comb begin
    if (cos_value_i > lpe_pkg::X_LIM) begin
      x_clamped = lpe_pkg::X_LIM;
    end else if (cos_value_i < -lpe_pkg::X_LIM) begin
      x_clamped = -lpe_pkg::X_LIM;
    end else begin
      x_clamped = cos_value_i;
    end
  end

  assign stat_o.in_deg_lt2 = (degree_i < lpe_pkg::DEG_W'(2));
  assign stat_o.last_step  = (n_q == deg_q);

  // operand magnitudes
  assign p1_mag  = p1_q[lpe_pkg::P1_W-1] ? lpe_pkg::P1_W'(-p1_q) : lpe_pkg::P1_W'(p1_q);
  assign x_mag   = x_q[lpe_pkg::X_W-1] ? lpe_pkg::X_W'(-x_q) : lpe_pkg::X_W'(x_q);
  assign num_mag = num_q[lpe_pkg::NUM_W-1] ? lpe_pkg::NUM_W'(-num_q)
                                           : lpe_pkg::NUM_W'(num_q);

  // multiplier operand selection
  always_comb begin
    case (cmd_i.mul_sel)
      lpe_pkg::MS_T: begin
        mul_a = lpe_pkg::MUL_A_W'(p1_mag);
        mul_b = lpe_pkg::MUL_B_W'(x_mag);
        neg_d = p1_q[lpe_pkg::P1_W-1] ^ x_q[lpe_pkg::X_W-1];
      end
      lpe_pkg::MS_Q: begin
        mul_a = lpe_pkg::MUL_A_W'(num_mag);
        mul_b = lpe_pkg::MUL_B_W'(recip_tbl[n_q]);
        neg_d = num_q[lpe_pkg::NUM_W-1];
      end
      lpe_pkg::MS_N: begin
        mul_a = lpe_pkg::MUL_A_W'(p1_mag);
        mul_b = fac_tbl[deg_q];
        neg_d = p1_q[lpe_pkg::P1_W-1];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        neg_d = 1'b0;
      end
    endcase
  end

  // two-pass magnitude multiply, low half of b then high half
  assign mul_b_part = cmd_i.mul_hi ? mul_b[lpe_pkg::MUL_B_W-1:lpe_pkg::MUL_BH_W]
                                   : mul_b[lpe_pkg::MUL_BH_W-1:0];
  assign mul_pp = lpe_pkg::MUL_P_W'(mul_a) * lpe_pkg::MUL_P_W'(mul_b_part);
  assign acc_d  = cmd_i.mul_hi ? acc_q + {mul_pp, {lpe_pkg::MUL_BH_W{1'b0}}}
                               : lpe_pkg::ACC_W'(mul_pp);

  // rounding to nearest, ties away from zero
  assign rnd_t = acc_q + lpe_pkg::HALF_T;
  assign rnd_q = acc_q + lpe_pkg::HALF_Q;
  assign t_mag = rnd_t[lpe_pkg::FRAC_BITS +: lpe_pkg::T_W];
  assign q_mag = rnd_q[lpe_pkg::RECIP_BITS +: lpe_pkg::Q_W];
  assign t_d   = neg_q ? lpe_pkg::T_W'(-$signed(t_mag)) : $signed(t_mag);
  assign q_s   = neg_q ? lpe_pkg::Q_W'(-$signed(q_mag)) : $signed(q_mag);

  // recurrence value saturated to +-2
  always_comb begin
    if (q_s > lpe_pkg::P_LIM) begin
      q_sat = lpe_pkg::P_LIM;
    end else if (q_s < -lpe_pkg::P_LIM) begin
      q_sat = -lpe_pkg::P_LIM;
    end else begin
      q_sat = q_s;
    end
  end

  // numerator n*(2t - p0) - (t - p0) = (2n-1)*t - (n-1)*p0
  assign d_d     = {t_q, 1'b0} - lpe_pkg::D_W'(p0_q);
  assign e_d     = t_q - lpe_pkg::E_W'(p0_q);
  assign nd_prod = lpe_pkg::NP_W'($signed({1'b0, n_q})) * lpe_pkg::NP_W'(d_q);
  assign num_d   = lpe_pkg::NUM_W'(nd_prod - lpe_pkg::NP_W'(e_q));

  // result saturated to +-4
  always_comb begin
    if (p1_q > lpe_pkg::OUT_LIM) begin
      value_d = lpe_pkg::VAL_W'(lpe_pkg::OUT_LIM);
    end else if (p1_q < -lpe_pkg::OUT_LIM) begin
      value_d = lpe_pkg::VAL_W'(-lpe_pkg::OUT_LIM);
    end else begin
      value_d = lpe_pkg::VAL_W'(p1_q);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      deg_q <= degree_i;
      x_q   <= x_clamped;
      n_q   <= lpe_pkg::DEG_W'(2);
      p0_q  <= lpe_pkg::P0_W'(lpe_pkg::P_ONE);
      p1_q  <= (degree_i == '0) ? lpe_pkg::P_ONE : lpe_pkg::P1_W'(x_clamped);
    end
    if (cmd_i.mul_en) begin
      acc_q <= acc_d;
      neg_q <= neg_d;
    end
    if (cmd_i.t_en) begin
      t_q <= t_d;
    end
    if (cmd_i.de_en) begin
      d_q <= d_d;
      e_q <= e_d;
    end
    if (cmd_i.num_en) begin
      num_q <= num_d;
    end
    if (cmd_i.q_en) begin
      p0_q <= lpe_pkg::P0_W'(p1_q);
      p1_q <= lpe_pkg::P1_W'(q_sat);
      n_q  <= n_q + lpe_pkg::DEG_W'(1);
    end
    if (cmd_i.nrm_en) begin
      p1_q <= lpe_pkg::P1_W'(q_s);
    end
    if (cmd_i.out_load) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

/* tb/legendre_polynomial_evaluator_top_test.sv */
module legendre_polynomial_evaluator_top_test;

  localparam int          HALF_PERIOD  = 5;
  localparam longint      RUN_LIMIT    = 64'd80_000_000;
  localparam int          DRAIN_CYCLES = 520;
  localparam int          MAX_DEG      = 63;
  localparam int          Q_FRAC       = 30;
  localparam int          Q_RECIP      = 48;
  localparam int          Q_SQRT       = 28;
  localparam longint      INV_TWO_SQRT_PI = (64'sd1211587905 <<< 16) + 64'sd2670;
  localparam longint      X_ONE        = 64'sd1 <<< Q_FRAC;
  localparam logic [2:0]  NORMALIZE_ADDR = 3'(4 * lpe_pkg::REG_NORMALIZE);

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic [lpe_pkg::DEG_W-1:0]           degree_i;
  logic signed [lpe_pkg::X_W-1:0]      cos_value_i;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [lpe_pkg::VAL_W-1:0]    value_o;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [2:0]                          paddr;
  logic [31:0]                         pwdata;
  logic [31:0]                         prdata;
  logic                                pready;

  // expected results in order of acceptance
  logic signed [lpe_pkg::VAL_W-1:0]    pending_values[$];
  logic signed [lpe_pkg::VAL_W-1:0]    oldest_value;
  bit                                  normalize_on;
  int                                  error_count;

  // sender bursts and receiver stalls
  int                       burst_left;
  int                       gap_pct;
  int                       max_gap;
  int                       stall_pct;
  int                       stall_hold;

  legendre_polynomial_evaluator_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .degree_i    (degree_i),
    .cos_value_i (cos_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // magnitude of a signed word
  function automatic logic [63:0] magnitude_of(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // hold a value within +-lim
  function automatic longint saturate(longint v, longint lim);
    if (v > lim) begin
      return lim;
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  // a*b / 2^sh rounded half away from zero, magnitude capped at 2^62
  function automatic longint round_product(longint a, longint b, int sh);
    logic [127:0] prod;
    logic [127:0] mag;
    bit           neg;
    neg  = (a < 0) != (b < 0);
    prod = 128'(magnitude_of(a)) * 128'(magnitude_of(b));
    prod = prod + (128'd1 << (sh - 1));
    mag  = prod >> sh;
    if (mag > (128'd1 << 62)) begin
      mag = 128'd1 << 62;
    end
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  // integer square root rounded to nearest
  function automatic logic [63:0] sqrt_nearest(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = 64'd0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    if (v - root * root > root) begin
      root = root + 64'd1;
    end
    return root;
  endfunction

  // P_l(x) by the Bonnet recurrence, optionally scaled to Y_l0
  function automatic logic signed [lpe_pkg::VAL_W-1:0] legendre_value(
      logic [lpe_pkg::DEG_W-1:0] deg, logic signed [lpe_pkg::X_W-1:0] cos_in, bit scale);
    int     l;
    longint x;
    longint p_prev;
    longint p_cur;
    longint t;
    longint num;
    longint recip;
    longint root;
    longint factor;
    l = (int'(deg) > MAX_DEG) ? MAX_DEG : int'(deg);
    x = saturate(longint'(cos_in), X_ONE);
    if (l == 0) begin
      p_cur = X_ONE;
    end else begin
      p_prev = X_ONE;
      p_cur  = x;
      for (int n = 2; n <= l; n++) begin
        t      = round_product(x, p_cur, Q_FRAC);
        num    = longint'(2 * n - 1) * t - longint'(n - 1) * p_prev;
        recip  = ((64'sd1 <<< Q_RECIP) + longint'(n / 2)) / longint'(n);
        p_prev = p_cur;
        p_cur  = saturate(round_product(num, recip, Q_RECIP), 64'sd1 <<< (Q_FRAC + 1));
      end
    end
    if (scale) begin
      root   = longint'(sqrt_nearest(64'(2 * l + 1) << (2 * Q_SQRT)));
      factor = round_product(root, INV_TWO_SQRT_PI, Q_SQRT);
      p_cur  = round_product(p_cur, factor, 48);
    end
    return lpe_pkg::VAL_W'(saturate(p_cur, 64'sd1 <<< 32));
  endfunction

  task automatic note_failure(string what, logic signed [lpe_pkg::VAL_W-1:0] want,
                              logic signed [lpe_pkg::VAL_W-1:0] got);
    error_count++;
    if (error_count <= 10) begin
      $display("%s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    end
  endtask

  // receiver stall pattern: runs of random length at a chosen density
  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      stall_hold  <= $urandom_range(7);
    end
  end

  // result check, sampled mid-cycle for the item taken at the next edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_values.size() == 0) begin
        note_failure("result with nothing expected", 'x, value_o);
      end else begin
        oldest_value = pending_values.pop_front();
        if (value_o !== oldest_value) begin
          note_failure("value mismatch", oldest_value, value_o);
        end
      end
    end
  end

  // one item: optional gap at a burst boundary, then hold until taken
  task automatic send_item(logic [lpe_pkg::DEG_W-1:0] deg,
                           logic signed [lpe_pkg::X_W-1:0] cos_in);
    bit taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(99) < gap_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, max_gap)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    degree_i    <= deg;
    cos_value_i <= cos_in;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    pending_values.push_back(legendre_value(deg, cos_in, normalize_on));
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_values.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // write the normalize register, then read it back
  task automatic apply_normalize(bit enable);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NORMALIZE_ADDR;
    pwdata  <= 32'(enable);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    normalize_on = enable;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    readback = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== 32'(enable)) begin
      note_failure("normalize readback", lpe_pkg::VAL_W'(enable),
                   lpe_pkg::VAL_W'(readback));
    end
  endtask

  // mostly low degrees, the slow ones now and then
  function automatic logic [lpe_pkg::DEG_W-1:0] random_degree();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      return lpe_pkg::DEG_W'($urandom_range(15));
    end
    if (pick < 95) begin
      return lpe_pkg::DEG_W'($urandom_range(63));
    end
    return lpe_pkg::DEG_W'(MAX_DEG);
  endfunction

  // mostly in range, some edges, some raw words beyond +-1
  function automatic logic signed [lpe_pkg::X_W-1:0] random_cos();
    int unsigned pick;
    longint      v;
    pick = $urandom_range(99);
    if (pick < 12) begin
      return $urandom;
    end
    if (pick < 24) begin
      case ($urandom_range(7))
        0:       v = X_ONE;
        1:       v = -X_ONE;
        2:       v = 0;
        3:       v = 1;
        4:       v = -1;
        5:       v = X_ONE - 1;
        6:       v = -X_ONE + 1;
        default: v = X_ONE + 1;
      endcase
      return lpe_pkg::X_W'(v);
    end
    v = longint'($urandom_range(32'h8000_0000)) - X_ONE;
    return lpe_pkg::X_W'(v);
  endfunction

  task automatic send_random_items(int count);
    for (int i = 0; i < count; i++) begin
      send_item(random_degree(), random_cos());
    end
  endtask

  // plain polynomial: low degrees, saturated arguments, the top degree
  task automatic test_directed_plain();
    gap_pct   = 40;
    max_gap   = 6;
    stall_pct = 30;
    apply_normalize(1'b0);
    send_item(6'd0,  32'sh1234_5678);
    send_item(6'd0,  32'sh8000_0000);
    send_item(6'd1,  lpe_pkg::X_W'(X_ONE));
    send_item(6'd1,  lpe_pkg::X_W'(-X_ONE));
    send_item(6'd1,  32'sh7FFF_FFFF);
    send_item(6'd1,  32'sh8000_0000);
    send_item(6'd1,  lpe_pkg::X_W'(X_ONE + 1));
    send_item(6'd1,  lpe_pkg::X_W'(-X_ONE - 1));
    send_item(6'd2,  32'sd0);
    send_item(6'd5,  lpe_pkg::X_W'(X_ONE / 2));
    send_item(6'd10, lpe_pkg::X_W'(-X_ONE / 3));
    send_item(6'd31, 32'shFFFF_FFFF);
    send_item(6'd63, lpe_pkg::X_W'(X_ONE));
    send_item(6'd63, lpe_pkg::X_W'(-X_ONE));
    send_item(6'd63, 32'sd0);
    send_item(6'd63, 32'sh7FFF_FFFF);
    wait_until_idle();
  endtask

  // normalised to Y_l0, including the largest factor at degree 63
  task automatic test_directed_normalized();
    apply_normalize(1'b1);
    send_item(6'd0,  32'sd0);
    send_item(6'd1,  lpe_pkg::X_W'(X_ONE));
    send_item(6'd2,  32'sd0);
    send_item(6'd7,  32'sh8000_0000);
    send_item(6'd63, lpe_pkg::X_W'(X_ONE));
    send_item(6'd63, lpe_pkg::X_W'(-X_ONE));
    wait_until_idle();
  endtask

  task automatic test_random_plain();
    gap_pct   = 50;
    max_gap   = 40;
    stall_pct = 30;
    apply_normalize(1'b0);
    send_random_items(700);
    wait_until_idle();
  endtask

  task automatic test_random_normalized();
    gap_pct   = 30;
    max_gap   = 25;
    stall_pct = 55;
    apply_normalize(1'b1);
    send_random_items(700);
    wait_until_idle();
  endtask

  // phases with the setting flipped, the first ones without any idling
  task automatic test_setting_changes();
    for (int phase = 0; phase < 5; phase++) begin
      gap_pct   = (phase < 2) ? 0 : 20;
      max_gap   = 10;
      stall_pct = (phase < 2) ? 0 : 15;
      apply_normalize(phase[0]);
      send_random_items(100);
      wait_until_idle();
    end
    apply_normalize(1'b0);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    degree_i     = '0;
    cos_value_i  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    normalize_on = 1'b0;
    error_count  = 0;
    burst_left   = 0;
    gap_pct      = 0;
    max_gap      = 1;
    stall_pct    = 0;
    stall_hold   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_plain();
    test_directed_normalized();
    test_random_plain();
    test_random_normalized();
    test_setting_changes();

    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    error_count += pending_values.size();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
